// ===== design/efc_pkg.sv =====
// Shared types and constants of the event FIFO with move coalescing.
package efc_pkg;

    localparam int CODE_W = 32;
    localparam int PRIO_W = 8;
    localparam int CNT_W  = 11;
    localparam int KIND_W = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        K_SEND    = 2'd0,
        K_RECEIVE = 2'd1,
        K_QUIT    = 2'd2,
        K_CLEAR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        R_CAPACITY = 2'd0,
        R_MOVE     = 2'd1,
        R_BTN_LOW  = 2'd2,
        R_BTN_HIGH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic [CODE_W-1:0] stamp;
    } t_entry;

    // Scan token that walks from the newest cell toward cell zero.
    typedef struct packed {
        logic valid;
        logic active;
        logic coalesced;
    } t_tok;

    typedef struct packed {
        logic [CODE_W-1:0] move_code;
        logic [CODE_W-1:0] btn_low;
        logic [CODE_W-1:0] btn_high;
    } t_match_cfg;

    typedef struct packed {
        logic   shift;
        logic   write;
        logic   start;
        t_entry data;
    } t_cell_ctl;

    typedef struct packed {
        logic              success;
        logic [CODE_W-1:0] out_code;
        logic [CODE_W-1:0] out_first;
        logic [CODE_W-1:0] out_second;
        logic [CODE_W-1:0] out_stamp;
        logic [CNT_W-1:0]  queued_count;
    } t_result;

endpackage

// ===== design/efc_if.sv =====
// Request and result channel interfaces.
interface efc_req_if;
    logic                        valid;
    logic                        ready;
    logic [efc_pkg::KIND_W-1:0]  kind;
    logic [efc_pkg::CODE_W-1:0]  message_code;
    logic [efc_pkg::CODE_W-1:0]  first_param;
    logic [efc_pkg::CODE_W-1:0]  second_param;
    logic [efc_pkg::PRIO_W-1:0]  priority_level;
    logic [efc_pkg::CODE_W-1:0]  stamp_now;
    modport source (output valid, kind, message_code, first_param, second_param,
                    priority_level, stamp_now, input ready);
    modport sink (input valid, kind, message_code, first_param, second_param,
                  priority_level, stamp_now, output ready);
endinterface

interface efc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       success;
    logic [efc_pkg::CODE_W-1:0] out_code;
    logic [efc_pkg::CODE_W-1:0] out_first;
    logic [efc_pkg::CODE_W-1:0] out_second;
    logic [efc_pkg::CODE_W-1:0] out_stamp;
    logic [efc_pkg::CNT_W-1:0]  queued_count;
    modport source (output valid, success, out_code, out_first, out_second, out_stamp,
                    queued_count, input ready);
    modport sink (input valid, success, out_code, out_first, out_second, out_stamp,
                  queued_count, output ready);
endinterface

// ===== design/event_fifo_with_move_coalescing_top.sv =====
// Top level: control, configuration registers and the chain of queue cells.
// Receive, quit, clear and walk-free sends give their result in the cycle after the request.
// An allowed send of the move code into a non-empty queue walks the cell chain one cell per cycle
// from the newest entry toward cell zero; one request is in work at a time.
// Synchronous active-low reset empties the queue, enables sending and loads register defaults.
// Entry contents are not cleared by reset.
module event_fifo_with_move_coalescing_top #(
    parameter int QUEUE_DEPTH     = 1024,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    efc_req_if.sink                      i_req,
    efc_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efc_pkg::ADDR_W-1:0]   paddr,
    input  logic [efc_pkg::DATA_W-1:0]   pwdata,
    output logic [efc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state                         r_state, n_state;
    logic [FILL_W-1:0]              r_fill, n_fill;
    logic                           r_enabled, n_enabled;
    logic [efc_pkg::CNT_W-1:0]      r_cap;
    efc_pkg::t_match_cfg            r_cfg;
    efc_pkg::t_entry                r_req, n_req;
    logic                           r_ovalid, n_ovalid;
    efc_pkg::t_result               r_res, n_res;

    efc_pkg::t_cell_ctl             w_ctl;
    efc_pkg::t_entry                w_in_ent;
    efc_pkg::t_entry                w_ent [QUEUE_DEPTH+1];
    efc_pkg::t_tok                  w_tok [QUEUE_DEPTH+1];
    logic                           w_accept;
    logic                           w_cfg_wr;
    logic [31:0]                    w_limit;
    logic                           w_send_ok;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap          <= efc_pkg::CAP_RESET;
            r_cfg          <= '0;
        end else if (w_cfg_wr) begin
            case (efc_pkg::t_reg_idx'(paddr[3:2]))
                efc_pkg::R_CAPACITY: r_cap          <= pwdata[efc_pkg::CNT_W-1:0];
                efc_pkg::R_MOVE:     r_cfg.move_code <= pwdata;
                efc_pkg::R_BTN_LOW:  r_cfg.btn_low  <= pwdata;
                efc_pkg::R_BTN_HIGH: r_cfg.btn_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (efc_pkg::t_reg_idx'(paddr[3:2]))
            efc_pkg::R_CAPACITY: prdata = 32'(r_cap);
            efc_pkg::R_MOVE:     prdata = r_cfg.move_code;
            efc_pkg::R_BTN_LOW:  prdata = r_cfg.btn_low;
            efc_pkg::R_BTN_HIGH: prdata = r_cfg.btn_high;
            default:             prdata = '0;
        endcase
    end

    // Request handling.
    assign i_req.ready = (r_state == ST_IDLE) && (!r_ovalid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_ent    = '{code: i_req.message_code, first: i_req.first_param,
                           second: i_req.second_param, stamp: i_req.stamp_now};
    assign w_limit     = (32'(r_cap) > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH) : 32'(r_cap);
    assign w_send_ok   = (32'(r_fill) < w_limit)
                      && (i_req.priority_level < efc_pkg::PRIO_W'(PRIORITY_LEVELS))
                      && r_enabled;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_enabled = r_enabled;
        n_req     = r_req;
        n_res     = r_res;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        w_ctl     = '{shift: 1'b0, write: 1'b0, start: 1'b0,
                      data: (r_state == ST_SCAN) ? r_req : w_in_ent};
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res    = '0;
                    n_ovalid = 1'b1;
                    case (efc_pkg::t_kind'(i_req.kind))
                        efc_pkg::K_SEND: begin
                            if (w_send_ok && (i_req.message_code == r_cfg.move_code)
                                && (r_fill != '0)) begin
                                w_ctl.start = 1'b1;
                                n_req       = w_in_ent;
                                n_ovalid    = 1'b0;
                                n_state     = ST_SCAN;
                            end else if (w_send_ok) begin
                                w_ctl.write   = 1'b1;
                                n_fill        = r_fill + 1'b1;
                                n_res.success = 1'b1;
                            end
                        end
                        efc_pkg::K_RECEIVE: begin
                            if (r_fill != '0) begin
                                w_ctl.shift      = 1'b1;
                                n_fill           = r_fill - 1'b1;
                                n_res.success    = 1'b1;
                                n_res.out_code   = w_ent[0].code;
                                n_res.out_first  = w_ent[0].first;
                                n_res.out_second = w_ent[0].second;
                                n_res.out_stamp  = w_ent[0].stamp;
                            end
                        end
                        efc_pkg::K_QUIT: n_enabled = 1'b0;
                        efc_pkg::K_CLEAR: n_fill = '0;
                        default: ;
                    endcase
                    n_res.queued_count = efc_pkg::CNT_W'(n_fill);
                end
            end
            ST_SCAN: begin
                // The token leaves cell zero once every stored entry was passed.
                if (w_tok[0].valid) begin
                    n_res = '0;
                    if (!w_tok[0].coalesced) begin
                        w_ctl.write = 1'b1;
                        n_fill      = r_fill + 1'b1;
                    end
                    n_res.success      = 1'b1;
                    n_res.queued_count = efc_pkg::CNT_W'(n_fill);
                    n_ovalid           = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_enabled <= 1'b1;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_enabled <= n_enabled;
            r_ovalid  <= n_ovalid;
        end
    end

    // Cell chain: cell 0 holds the oldest entry.
    assign w_ent[QUEUE_DEPTH] = '0;
    assign w_tok[QUEUE_DEPTH] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        efc_cell #(
            .IDX    (g),
            .FILL_W (FILL_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_cfg    (r_cfg),
            .i_fill   (r_fill),
            .i_up_ent (w_ent[g+1]),
            .i_up_tok (w_tok[g+1]),
            .o_ent    (w_ent[g]),
            .o_tok    (w_tok[g])
        );
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.success      = r_res.success;
    assign o_rsp.out_code     = r_res.out_code;
    assign o_rsp.out_first    = r_res.out_first;
    assign o_rsp.out_second   = r_res.out_second;
    assign o_rsp.out_stamp    = r_res.out_stamp;
    assign o_rsp.queued_count = r_res.queued_count;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(QUEUE_DEPTH))
        else $error("fill count exceeds queue depth");

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[0].valid |-> (r_state == ST_SCAN))
        else $error("scan token left the chain outside a scan");

    a_scan_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !r_ovalid)
        else $error("result pending while a scan is running");

    a_quit_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enabled |=> !r_enabled)
        else $error("sending re-enabled without reset");
endmodule

// ===== design/efc_cell.sv =====
// One queue cell: holds one entry, shifts toward the head, and checks the scan token.
module efc_cell #(
    parameter int IDX    = 0,
    parameter int FILL_W = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  efc_pkg::t_cell_ctl   i_ctl,
    input  efc_pkg::t_match_cfg  i_cfg,
    input  logic [FILL_W-1:0]    i_fill,
    input  efc_pkg::t_entry      i_up_ent,
    input  efc_pkg::t_tok        i_up_tok,
    output efc_pkg::t_entry      o_ent,
    output efc_pkg::t_tok        o_tok
);
    efc_pkg::t_entry r_ent, n_ent;
    efc_pkg::t_tok   r_tok, n_tok;
    efc_pkg::t_tok   w_tok_in;
    logic            w_btn;

    always_comb begin
        // The newest entry sits at fill-1; the token enters the chain there.
        if (i_ctl.start && (i_fill == FILL_W'(IDX + 1))) begin
            w_tok_in = '{valid: 1'b1, active: 1'b1, coalesced: 1'b0};
        end else begin
            w_tok_in = i_up_tok;
        end
        w_btn = (r_ent.code >= i_cfg.btn_low) && (r_ent.code <= i_cfg.btn_high);
        n_ent = r_ent;
        n_tok = w_tok_in;
        if (i_ctl.shift) begin
            n_ent = i_up_ent;
        end else if (i_ctl.write && (i_fill == FILL_W'(IDX))) begin
            n_ent = i_ctl.data;
        end
        if (w_tok_in.valid && w_tok_in.active) begin
            if (w_btn) begin
                n_tok.active = 1'b0;
            end else if (r_ent.code == i_cfg.move_code) begin
                n_tok.active    = 1'b0;
                n_tok.coalesced = 1'b1;
                n_ent.first     = i_ctl.data.first;
                n_ent.second    = i_ctl.data.second;
                n_ent.stamp     = i_ctl.data.stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_ent = r_ent;
    assign o_tok = r_tok;
endmodule

// ===== bench/efc_checker.sv =====
// Watches the request, result and register ports, predicts each result and compares it.
module efc_checker #(
    parameter int QUEUE_DEPTH     = 1024,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    efc_req_if                         i_req,
    efc_rsp_if                         i_rsp,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [efc_pkg::ADDR_W-1:0] i_paddr,
    input  logic [efc_pkg::DATA_W-1:0] i_pwdata,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    logic [efc_pkg::CODE_W-1:0] q_code   [QUEUE_DEPTH];
    logic [efc_pkg::CODE_W-1:0] q_first  [QUEUE_DEPTH];
    logic [efc_pkg::CODE_W-1:0] q_second [QUEUE_DEPTH];
    logic [efc_pkg::CODE_W-1:0] q_stamp  [QUEUE_DEPTH];
    int                         head, tail, fill;
    bit                         sending_on;
    logic [efc_pkg::CNT_W-1:0]  capacity;
    logic [efc_pkg::CODE_W-1:0] move_code, btn_low, btn_high;
    efc_pkg::t_result           pending_results[$];
    int                         fails;

    initial begin
        fails = 0;
    end

    function automatic bit try_send(logic [efc_pkg::CODE_W-1:0] code,
                                    logic [efc_pkg::CODE_W-1:0] p1,
                                    logic [efc_pkg::CODE_W-1:0] p2,
                                    logic [efc_pkg::PRIO_W-1:0] prio,
                                    logic [efc_pkg::CODE_W-1:0] stamp);
        int lim;
        int pos;
        logic [efc_pkg::CODE_W-1:0] c;
        lim = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(capacity);
        if (fill >= lim || prio >= PRIORITY_LEVELS || !sending_on) return 1'b0;
        if (code == move_code) begin
            pos = tail;
            for (int n = 0; n < fill; n++) begin
                pos = (pos == 0) ? QUEUE_DEPTH - 1 : pos - 1;
                c = q_code[pos];
                if (c >= btn_low && c <= btn_high) break;
                if (c == move_code) begin
                    // Merge into the newest pending move instead of queuing a new one.
                    q_first[pos] = p1;
                    q_second[pos] = p2;
                    q_stamp[pos] = stamp;
                    return 1'b1;
                end
            end
        end
        q_code[tail] = code;
        q_first[tail] = p1;
        q_second[tail] = p2;
        q_stamp[tail] = stamp;
        tail = (tail + 1 >= QUEUE_DEPTH) ? 0 : tail + 1;
        fill++;
        return 1'b1;
    endfunction

    function automatic efc_pkg::t_result predict_result();
        efc_pkg::t_result r;
        r = '0;
        case (efc_pkg::t_kind'(i_req.kind))
            efc_pkg::K_SEND: begin
                r.success = try_send(i_req.message_code, i_req.first_param,
                                     i_req.second_param, i_req.priority_level,
                                     i_req.stamp_now);
            end
            efc_pkg::K_RECEIVE: begin
                if (fill > 0) begin
                    r.success = 1'b1;
                    r.out_code = q_code[head];
                    r.out_first = q_first[head];
                    r.out_second = q_second[head];
                    r.out_stamp = q_stamp[head];
                    head = (head + 1 >= QUEUE_DEPTH) ? 0 : head + 1;
                    fill--;
                end
            end
            efc_pkg::K_QUIT: sending_on = 1'b0;
            default: begin
                fill = 0;
                head = tail;
            end
        endcase
        r.queued_count = fill[efc_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [efc_pkg::CODE_W-1:0] exp_v,
                                        logic [efc_pkg::CODE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch in %s: expected %h, got %h", $time, name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        efc_pkg::t_result exp_r;
        if (!i_rst_n) begin
            head = 0;
            tail = 0;
            fill = 0;
            sending_on = 1'b1;
            capacity = efc_pkg::CAP_RESET;
            move_code = '0;
            btn_low = '0;
            btn_high = '0;
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (efc_pkg::t_reg_idx'(i_paddr[3:2]))
                    efc_pkg::R_CAPACITY: capacity = i_pwdata[efc_pkg::CNT_W-1:0];
                    efc_pkg::R_MOVE:     move_code = i_pwdata;
                    efc_pkg::R_BTN_LOW:  btn_low = i_pwdata;
                    default:             btn_high = i_pwdata;
                endcase
            end
            // A result leaving now belongs to an earlier request, so compare first.
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, got count %0d", $time,
                             i_rsp.queued_count);
                    fails++;
                end else begin
                    exp_r = pending_results.pop_front();
                    check_field("success", 32'(exp_r.success), 32'(i_rsp.success));
                    check_field("out_code", exp_r.out_code, i_rsp.out_code);
                    check_field("out_first", exp_r.out_first, i_rsp.out_first);
                    check_field("out_second", exp_r.out_second, i_rsp.out_second);
                    check_field("out_stamp", exp_r.out_stamp, i_rsp.out_stamp);
                    check_field("queued_count", 32'(exp_r.queued_count),
                                32'(i_rsp.queued_count));
                end
            end
            if (i_req.valid && i_req.ready) pending_results.push_back(predict_result());
        end
        o_outstanding <= pending_results.size();
        o_fail_count <= fails;
    end
endmodule

// ===== bench/tb.sv =====
// Top of the event FIFO bench: clock, reset, request and register stimulus, and the verdict.
module tb;
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [efc_pkg::ADDR_W-1:0]  paddr = '0;
    logic [efc_pkg::DATA_W-1:0]  pwdata = '0;
    logic [efc_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        result_ready = 1'b0;
    int                          fail_count;
    int                          outstanding;
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;
    int                          request_total = 0;
    logic [efc_pkg::CODE_W-1:0]  cur_move = '0, cur_low = '0, cur_high = '0;

    efc_req_if req();
    efc_rsp_if rsp();

    assign rsp.ready = result_ready;

    event_fifo_with_move_coalescing_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    efc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .i_rsp(rsp),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        req.valid = 1'b0;
        req.kind = efc_pkg::K_SEND;
        req.message_code = '0;
        req.first_param = '0;
        req.second_param = '0;
        req.priority_level = '0;
        req.stamp_now = '0;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d results still owed.", outstanding);
        $display("== FAIL ==");
        $finish;
    end

    task automatic issue_request(efc_pkg::t_kind kind, logic [efc_pkg::CODE_W-1:0] code,
                                 logic [efc_pkg::CODE_W-1:0] p1,
                                 logic [efc_pkg::CODE_W-1:0] p2,
                                 logic [efc_pkg::PRIO_W-1:0] prio,
                                 logic [efc_pkg::CODE_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.message_code <= code;
        req.first_param <= p1;
        req.second_param <= p2;
        req.priority_level <= prio;
        req.stamp_now <= stamp;
        do @(posedge i_clk); while (!req.ready);
        request_total++;
    endtask

    task automatic send_msg(logic [efc_pkg::CODE_W-1:0] code,
                            logic [efc_pkg::PRIO_W-1:0] prio = 0);
        issue_request(efc_pkg::K_SEND, code, $urandom, $urandom, prio, $urandom);
    endtask

    task automatic simple_request(efc_pkg::t_kind kind);
        issue_request(kind, $urandom, $urandom, $urandom, efc_pkg::PRIO_W'($urandom),
                      $urandom);
    endtask

    // Stops the request stream and waits until every result has come back.
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Leaves psel high after the access cycle so the next write can start at once.
    task automatic write_register(efc_pkg::t_reg_idx idx, logic [efc_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= efc_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            efc_pkg::R_MOVE:     cur_move = value;
            efc_pkg::R_BTN_LOW:  cur_low = value;
            efc_pkg::R_BTN_HIGH: cur_high = value;
            default:             ;
        endcase
    endtask

    task automatic configure(logic [efc_pkg::CNT_W-1:0] cap, logic [efc_pkg::CODE_W-1:0] mv,
                             logic [efc_pkg::CODE_W-1:0] lo,
                             logic [efc_pkg::CODE_W-1:0] hi);
        drain_results();
        write_register(efc_pkg::R_CAPACITY, 32'(cap));
        write_register(efc_pkg::R_MOVE, mv);
        write_register(efc_pkg::R_BTN_LOW, lo);
        write_register(efc_pkg::R_BTN_HIGH, hi);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_requests(int count);
        int pick;
        logic [efc_pkg::CODE_W-1:0] code;
        logic [efc_pkg::PRIO_W-1:0] prio;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 52) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: code = cur_move;
                    5, 6: code = (cur_low <= cur_high) ?
                                 efc_pkg::CODE_W'(cur_low +
                                     ($urandom % (cur_high - cur_low + 64'd1))) :
                                 $urandom;
                    default: code = $urandom;
                endcase
                prio = ($urandom_range(9) == 0) ? efc_pkg::PRIO_W'($urandom_range(255)) :
                                                  efc_pkg::PRIO_W'($urandom_range(3));
                send_msg(code, prio);
            end else if (pick < 95) begin
                simple_request(efc_pkg::K_RECEIVE);
            end else begin
                simple_request(efc_pkg::K_CLEAR);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: coalescing, button range stop, priority refusal, field extremes.
        configure(efc_pkg::CAP_RESET, 32'd5, 32'd10, 32'd20);
        simple_request(efc_pkg::K_RECEIVE);
        send_msg(32'd5);
        send_msg(32'd5);
        send_msg(32'd12);
        send_msg(32'd5);
        send_msg(32'd7);
        send_msg(32'd5);
        send_msg(32'd9, 8'd4);
        send_msg(32'd9, 8'd255);
        issue_request(efc_pkg::K_SEND, '1, '1, '1, 8'd3, '1);
        issue_request(efc_pkg::K_SEND, '0, '0, '0, 8'd0, '0);
        repeat (7) simple_request(efc_pkg::K_RECEIVE);
        send_msg(32'd3);
        simple_request(efc_pkg::K_CLEAR);
        simple_request(efc_pkg::K_RECEIVE);

        // Full queue refuses a third move; a move code inside the button range never merges.
        configure(11'd2, 32'd15, 32'd10, 32'd20);
        send_msg(32'd15);
        send_msg(32'd15);
        send_msg(32'd15);
        simple_request(efc_pkg::K_RECEIVE);
        simple_request(efc_pkg::K_RECEIVE);
        simple_request(efc_pkg::K_RECEIVE);

        // Lowered capacity below the fill keeps the entries receivable.
        configure(11'd2047, '1, 32'd0, '1);
        repeat (4) send_msg($urandom_range(100));
        configure(11'd1, '1, 32'd0, '1);
        send_msg('1);
        repeat (4) simple_request(efc_pkg::K_RECEIVE);

        send_idle_pct = 14;
        recv_idle_pct = 61;
        configure(efc_pkg::CAP_RESET, 32'd5, 32'd10, 32'd20);
        random_requests(200);

        send_idle_pct = 61;
        recv_idle_pct = 14;
        configure(11'd2047, 32'd15, 32'd10, 32'd20);
        random_requests(180);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Empty button range: nothing stops the walk toward the oldest move.
        configure(11'd8, 32'hFFFF_FFFF, 32'd100, 32'd50);
        random_requests(130);
        configure(11'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_requests(25);

        // Quit is permanent, so it comes last.
        configure(efc_pkg::CAP_RESET, 32'd5, 32'd10, 32'd20);
        send_msg(32'd1);
        simple_request(efc_pkg::K_QUIT);
        send_msg(32'd1);
        simple_request(efc_pkg::K_RECEIVE);
        send_msg(32'd5);
        simple_request(efc_pkg::K_CLEAR);
        simple_request(efc_pkg::K_RECEIVE);

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d requests: coalescing, button stops, refusals, capacity limits,",
                 request_total);
        $display("clear and quit, under sender and receiver stalls.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
